/* rtl/core/bdq_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the bounded deque with masked search.
// No dependencies; every other file of the block imports this package.
package bdq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WIDTH_DEF = 32;
    localparam int ITEM_W    = 32;
    localparam int REQ_W     = 4;
    localparam int STATUS_W  = 2;
    localparam int CNT_W_DEF = $clog2(DEPTH_DEF + 1);

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 4'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 4'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 4'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 4'd3;
    localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 4'd4;
    localparam logic [REQ_W-1:0] REQ_PEEK_BACK  = 4'd5;
    localparam logic [REQ_W-1:0] REQ_REMOVE     = 4'd6;
    localparam logic [REQ_W-1:0] REQ_FIND       = 4'd7;
    localparam logic [REQ_W-1:0] REQ_DUMP       = 4'd8;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd3;

    // Per-cycle command to every cell; shift and load bits set only when the request succeeds.
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic remove;
        logic rd_find;
    } t_cell_ctrl;

endpackage

/* rtl/core/bdq_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results of the deque.
// Depends on bdq_pkg.
interface bdq_req_if
    import bdq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [ITEM_W-1:0] item_value;

    modport source (output valid, output req_type, output item_value, input ready);
    modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

interface bdq_res_if
    import bdq_pkg::*;
#(
    parameter int CNT_W = CNT_W_DEF
) ();
    logic                valid;
    logic                ready;
    logic [ITEM_W-1:0]   result_item;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    occupancy;
    logic                last;

    modport source (output valid, output result_item, output status, output occupancy,
                    output last, input ready);
    modport sink   (input valid, input result_item, input status, input occupancy,
                    input last, output ready);
endinterface

/* rtl/core/bounded_deque_with_search.sv */
`timescale 1ns / 1ps
// Bounded double-ended queue with masked search, built as a row of DEPTH cells that
// shift, compare and load in parallel. Each request other than a non-empty dump gives
// one result transaction through a single output register, so a new request is taken
// in the cycle the previous result is taken. A dump of N entries streams N results,
// one per cycle unless the output stalls, reading the chain by index; no request
// is taken until its last result is loaded. Depends on bdq_pkg, bdq_if and bdq_cell.
module bounded_deque_with_search
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int WIDTH = WIDTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ITEM_W-1:0] i_cfg_data,
    bdq_req_if.sink           i_req,
    bdq_res_if.source         o_res
);

    localparam int EXT_W = (WIDTH > ITEM_W) ? WIDTH : ITEM_W;

    logic [ITEM_W-1:0]   r_mask;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic                r_dump;
    logic [CNT_W-1:0]    r_didx;
    logic                r_ov;
    logic                n_ov;
    logic [ITEM_W-1:0]   r_item;
    logic [STATUS_W-1:0] r_status;
    logic                r_last;

    logic                accept;
    logic                slot_free;
    logic                full;
    logic                empty;
    logic                any_hit;
    t_cell_ctrl          ctrl;
    logic [CNT_W-1:0]    rd_idx;
    logic [EXT_W-1:0]    val_ext;
    logic [EXT_W-1:0]    mask_ext;
    logic [EXT_W-1:0]    rd_ext;
    logic [WIDTH-1:0]    val;
    logic [WIDTH-1:0]    mask;
    logic [ITEM_W-1:0]   rd_item;
    logic [ITEM_W-1:0]   n_item;
    logic [STATUS_W-1:0] n_status;

    logic [WIDTH-1:0]    data [DEPTH];
    logic [WIDTH-1:0]    rd_chain [DEPTH+1];
    logic                hit_chain [DEPTH+1];

    assign val_ext  = EXT_W'(i_req.item_value);
    assign val      = val_ext[WIDTH-1:0];
    assign mask_ext = EXT_W'(r_mask);
    assign mask     = mask_ext[WIDTH-1:0];
    assign rd_ext   = EXT_W'(rd_chain[DEPTH]);
    assign rd_item  = rd_ext[ITEM_W-1:0];

    assign full      = r_count == CNT_W'(DEPTH);
    assign empty     = r_count == '0;
    assign any_hit   = hit_chain[DEPTH];
    assign slot_free = !r_ov || o_res.ready;
    assign i_req.ready = !r_dump && slot_free;
    assign accept    = i_req.valid && i_req.ready;

    assign rd_chain[0]  = '0;
    assign hit_chain[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [WIDTH-1:0] left;
            logic [WIDTH-1:0] right;
            if (g == 0) begin : g_head
                assign left = val;
            end else begin : g_mid_l
                assign left = data[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign right = '0;
            end else begin : g_mid_r
                assign right = data[g+1];
            end
            bdq_cell #(
                .WIDTH (WIDTH),
                .CNT_W (CNT_W),
                .IDX   (g)
            ) u_cell (
                .i_clk    (i_clk),
                .i_ctrl   (ctrl),
                .i_val    (val),
                .i_key    (val),
                .i_mask   (mask),
                .i_count  (r_count),
                .i_rd_idx (rd_idx),
                .i_left   (left),
                .i_right  (right),
                .i_hit    (hit_chain[g]),
                .i_rd     (rd_chain[g]),
                .o_data   (data[g]),
                .o_hit    (hit_chain[g+1]),
                .o_rd     (rd_chain[g+1])
            );
        end
    endgenerate

    // Decode the request into cell commands, the next count and the result.
    always_comb begin
        ctrl     = '0;
        n_count  = r_count;
        n_item   = '0;
        n_status = ST_OK;
        rd_idx   = r_dump ? r_didx : '0;
        case (i_req.req_type)
            REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ctrl.push_front = accept && (i_req.req_type == REQ_PUSH_FRONT);
                    ctrl.push_back  = accept && (i_req.req_type == REQ_PUSH_BACK);
                    n_count = r_count + 1'b1;
                end
            end
            REQ_POP_FRONT, REQ_PEEK_FRONT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_item = rd_item;
                    if (i_req.req_type == REQ_POP_FRONT) begin
                        ctrl.pop_front = accept;
                        n_count = r_count - 1'b1;
                    end
                end
            end
            REQ_POP_BACK, REQ_PEEK_BACK: begin
                if (!r_dump) begin
                    rd_idx = r_count - 1'b1;
                end
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_item = rd_item;
                    if (i_req.req_type == REQ_POP_BACK) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            REQ_REMOVE: begin
                if (!any_hit) begin
                    n_status = ST_NOMATCH;
                end else begin
                    ctrl.remove = accept;
                    n_count = r_count - 1'b1;
                end
            end
            REQ_FIND: begin
                ctrl.rd_find = !r_dump;
                if (!any_hit) begin
                    n_status = ST_NOMATCH;
                end else begin
                    n_item = rd_item;
                end
            end
            REQ_DUMP: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_ov = r_ov && !o_res.ready;
        if (r_dump) begin
            if (slot_free) begin
                n_ov = 1'b1;
            end
        end else if (accept && !(i_req.req_type == REQ_DUMP && !empty)) begin
            n_ov = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '1;
            r_count <= '0;
            r_dump  <= 1'b0;
            r_didx  <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mask <= i_cfg_data;
            end
            r_ov <= n_ov;
            if (r_dump) begin
                if (slot_free) begin
                    r_item   <= rd_item;
                    r_status <= ST_OK;
                    r_last   <= r_didx == r_count - 1'b1;
                    r_didx   <= r_didx + 1'b1;
                    if (r_didx == r_count - 1'b1) begin
                        r_dump <= 1'b0;
                    end
                end
            end else if (accept) begin
                r_count <= n_count;
                if (i_req.req_type == REQ_DUMP && !empty) begin
                    // Results of a dump are streamed from the following cycle.
                    r_dump <= 1'b1;
                    r_didx <= '0;
                end else begin
                    r_item   <= n_item;
                    r_status <= n_status;
                    r_last   <= 1'b1;
                end
            end
        end
    end

    assign o_res.valid       = r_ov;
    assign o_res.result_item = r_item;
    assign o_res.status      = r_status;
    assign o_res.occupancy   = r_count;
    assign o_res.last        = r_last;

endmodule

/* rtl/core/bdq_cell.sv */
`timescale 1ns / 1ps
// One storage cell of the deque chain: holds the entry at position IDX.
// Depends on bdq_pkg; instantiated in a row by bounded_deque_with_search.
module bdq_cell
    import bdq_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF,
    parameter int CNT_W = CNT_W_DEF,
    parameter int IDX   = 0
) (
    input  logic             i_clk,
    input  t_cell_ctrl       i_ctrl,
    input  logic [WIDTH-1:0] i_val,
    input  logic [WIDTH-1:0] i_key,
    input  logic [WIDTH-1:0] i_mask,
    input  logic [CNT_W-1:0] i_count,
    input  logic [CNT_W-1:0] i_rd_idx,
    input  logic [WIDTH-1:0] i_left,
    input  logic [WIDTH-1:0] i_right,
    input  logic             i_hit,
    input  logic [WIDTH-1:0] i_rd,
    output logic [WIDTH-1:0] o_data,
    output logic             o_hit,
    output logic [WIDTH-1:0] o_rd
);

    logic [WIDTH-1:0] r_data;
    logic [WIDTH-1:0] n_data;
    logic             occupied;
    logic             my_hit;
    logic             first;
    logic             rd_sel;

    assign occupied = CNT_W'(IDX) < i_count;
    assign my_hit   = occupied && (((r_data ^ i_key) & i_mask) == '0);
    // The hit flag ripples toward the back, so it is high at and after the first match.
    assign o_hit    = i_hit | my_hit;
    assign first    = my_hit & ~i_hit;
    assign rd_sel   = i_ctrl.rd_find ? first : (CNT_W'(IDX) == i_rd_idx);
    assign o_rd     = i_rd | (rd_sel ? r_data : '0);
    assign o_data   = r_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.push_front) begin
            n_data = i_left;
        end else if (i_ctrl.push_back) begin
            if (CNT_W'(IDX) == i_count) begin
                n_data = i_val;
            end
        end else if (i_ctrl.pop_front) begin
            n_data = i_right;
        end else if (i_ctrl.remove && o_hit) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for bounded_deque_with_search: a shadow deque predicts every result.
// Depends on bdq_pkg, bdq_if and the block's RTL.
module testbench;
    import bdq_pkg::*;

    localparam int QUEUE_DEPTH = DEPTH_DEF;
    localparam int IDLE_LIMIT  = 2000;
    localparam int MAX_REPORTS = 10;
    localparam int N_PHASES    = 5;
    localparam int PHASE_ITEMS = 24;

    // Request codes with no operation behind them.
    localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 4'd9;
    localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 4'd15;

    typedef struct {
        logic [REQ_W-1:0]     req;
        logic [ITEM_W-1:0]    item;
        logic [STATUS_W-1:0]  status;
        logic [CNT_W_DEF-1:0] occupancy;
        logic                 last;
    } t_deque_result;

    // Shadow copy of the deque and the results it predicts, oldest first.
    class t_deque_shadow;
        logic [ITEM_W-1:0] words[$];
        logic [ITEM_W-1:0] mask = '1;
        t_deque_result     pending[$];
        int n_requests = 0;
        int n_results  = 0;
        int n_full     = 0;
        int n_empty    = 0;
        int n_nomatch  = 0;
        int errors     = 0;

        function int match_pos(logic [ITEM_W-1:0] key);
            foreach (words[i]) begin
                if (((words[i] ^ key) & mask) == '0) return i;
            end
            return -1;
        endfunction

        function void queue_result(logic [REQ_W-1:0] req, logic [ITEM_W-1:0] item,
                                   logic [STATUS_W-1:0] st, logic lst);
            t_deque_result r;
            r.req       = req;
            r.item      = item;
            r.status    = st;
            r.occupancy = CNT_W_DEF'(words.size());
            r.last      = lst;
            pending.push_back(r);
            if (st == ST_FULL) n_full++;
            if (st == ST_EMPTY) n_empty++;
            if (st == ST_NOMATCH) n_nomatch++;
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [ITEM_W-1:0] val);
            logic [ITEM_W-1:0]   item;
            logic [STATUS_W-1:0] st;
            int                  pos;
            item = '0;
            st   = ST_OK;
            n_requests++;
            case (req)
                REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                    if (words.size() >= QUEUE_DEPTH) st = ST_FULL;
                    else if (req == REQ_PUSH_FRONT) words.push_front(val);
                    else words.push_back(val);
                end
                REQ_POP_FRONT, REQ_PEEK_FRONT: begin
                    if (words.size() == 0) begin
                        st = ST_EMPTY;
                    end else begin
                        item = words[0];
                        if (req == REQ_POP_FRONT) void'(words.pop_front());
                    end
                end
                REQ_POP_BACK, REQ_PEEK_BACK: begin
                    if (words.size() == 0) begin
                        st = ST_EMPTY;
                    end else begin
                        item = words[words.size() - 1];
                        if (req == REQ_POP_BACK) void'(words.pop_back());
                    end
                end
                REQ_REMOVE: begin
                    pos = match_pos(val);
                    if (pos < 0) st = ST_NOMATCH;
                    else words.delete(pos);
                end
                REQ_FIND: begin
                    pos = match_pos(val);
                    if (pos < 0) st = ST_NOMATCH;
                    else item = words[pos];
                end
                REQ_DUMP: begin
                    if (words.size() == 0) begin
                        st = ST_EMPTY;
                    end else begin
                        // One transaction per entry, front first, last flag on the back entry.
                        foreach (words[i])
                            queue_result(req, words[i], ST_OK, i == words.size() - 1);
                        return;
                    end
                end
                default: ;
            endcase
            queue_result(req, item, st, 1'b1);
        endfunction

        function void check_result(logic [ITEM_W-1:0] item, logic [STATUS_W-1:0] st,
                                   logic [CNT_W_DEF-1:0] occ, logic lst);
            t_deque_result want;
            n_results++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result %0d: item %h status %0d occupancy %0d last %0d",
                             n_results, item, st, occ, lst);
                return;
            end
            want = pending.pop_front();
            if (want.item !== item || want.status !== st || want.occupancy !== occ ||
                want.last !== lst) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $write("mismatch on result %0d (request %0d), expected/actual: ",
                           n_results, want.req);
                    $display("item %h/%h status %0d/%0d occupancy %0d/%0d last %0d/%0d",
                             want.item, item, want.status, st,
                             want.occupancy, occ, want.last, lst);
                end
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic cfg_we  = 1'b0;
    logic [ITEM_W-1:0] cfg_data = '0;
    bit   send_burst = 1'b0;
    bit   recv_burst = 1'b0;
    int   idle_cycles = 0;
    int   n_masks = 0;

    t_deque_shadow sb = new();

    bdq_req_if req_ch ();
    bdq_res_if #(.CNT_W(CNT_W_DEF)) res_ch ();

    bounded_deque_with_search dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch.sink),
        .o_res      (res_ch.source)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        req_ch.valid      = 1'b0;
        req_ch.req_type   = '0;
        req_ch.item_value = '0;
        res_ch.ready      = 1'b0;
    end

    // Fails the run when neither channel moves a transaction for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                     (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random stalls outside burst phases, every accepted transaction is checked.
    initial begin
        int gap;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = recv_burst ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid === 1'b1 && res_ch.ready === 1'b1));
            sb.check_result(res_ch.result_item, res_ch.status, res_ch.occupancy, res_ch.last);
        end
    end

    task automatic issue_request(input logic [REQ_W-1:0] req, input logic [ITEM_W-1:0] val);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= req;
        req_ch.item_value <= val;
        do @(posedge i_clk); while (!(req_ch.valid === 1'b1 && req_ch.ready === 1'b1));
        sb.note_request(req, val);
    endtask

    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_mask(input logic [ITEM_W-1:0] m);
        wait_for_results();
        repeat (2) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        sb.mask = m;
        n_masks++;
    endtask

    // Half the words are small values so that duplicates and masked collisions are common.
    function automatic logic [ITEM_W-1:0] random_word();
        return $urandom_range(0, 1) ? ITEM_W'($urandom) : ITEM_W'($urandom_range(0, 7));
    endfunction

    // Usually a held entry with noise in the ignored bits, so searches tend to hit.
    function automatic logic [ITEM_W-1:0] search_key();
        int idx;
        if (sb.words.size() > 0 && $urandom_range(0, 3) != 0) begin
            idx = $urandom_range(0, sb.words.size() - 1);
            return sb.words[idx] ^ (ITEM_W'($urandom) & ~sb.mask);
        end
        return random_word();
    endfunction

    task automatic run_random_phase(input int n_items, input int push_pct);
        int                roll;
        logic [REQ_W-1:0]  req;
        logic [ITEM_W-1:0] val;
        for (int i = 0; i < n_items; i++) begin
            roll = $urandom_range(0, 99);
            val  = random_word();
            if (roll < push_pct) begin
                req = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 15) req = REQ_POP_FRONT;
                else if (roll < 30) req = REQ_POP_BACK;
                else if (roll < 40) req = REQ_PEEK_FRONT;
                else if (roll < 50) req = REQ_PEEK_BACK;
                else if (roll < 68) req = REQ_REMOVE;
                else if (roll < 86) req = REQ_FIND;
                else if (roll < 96) req = REQ_DUMP;
                else req = REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
                if (req == REQ_REMOVE || req == REQ_FIND) val = search_key();
            end
            issue_request(req, val);
        end
    endtask

    initial begin
        logic [ITEM_W-1:0] phase_mask [N_PHASES];
        int                phase_push [N_PHASES];
        phase_mask[0] = 32'hFFFF_FFFF;
        phase_mask[1] = 32'h0000_0000;
        phase_mask[2] = 32'h0000_00FF;
        phase_mask[3] = 32'hFFFF_0000;
        phase_mask[4] = $urandom;
        phase_push[0] = 70;
        phase_push[1] = 30;
        phase_push[2] = 60;
        phase_push[3] = 45;
        phase_push[4] = 50;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Requests on an empty deque.
        issue_request(REQ_POP_FRONT, '0);
        issue_request(REQ_PEEK_BACK, '1);
        issue_request(REQ_FIND, 32'h0);
        issue_request(REQ_DUMP, '0);
        // Fill from both ends with the extreme words first, then overflow.
        for (int i = 0; i < QUEUE_DEPTH; i++)
            issue_request(i[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT,
                          (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : ITEM_W'($urandom));
        issue_request(REQ_PUSH_BACK, 32'hA5A5_5A5A);
        issue_request(REQ_DUMP, '0);
        issue_request(REQ_PEEK_FRONT, '0);
        issue_request(REQ_FIND, sb.words[9]);
        issue_request(REQ_REMOVE, sb.words[5]);
        issue_request(REQ_POP_BACK, '0);
        issue_request(REQ_UNUSED_LO, 32'h1234_5678);
        issue_request(REQ_UNUSED_HI, '1);

        for (int k = 0; k < N_PHASES; k++) begin
            write_mask(phase_mask[k]);
            send_burst = (k == 1);
            recv_burst = (k == 1) || (k == 3);
            run_random_phase(PHASE_ITEMS, phase_push[k]);
        end

        wait_for_results();
        repeat (8) @(posedge i_clk);

        $display("Ran %0d requests and checked %0d result transactions under %0d masks.",
                 sb.n_requests, sb.n_results, n_masks + 1);
        $display("Flagged outcomes: %0d full, %0d empty, %0d without a match.",
                 sb.n_full, sb.n_empty, sb.n_nomatch);
        if (sb.pending.size() != 0)
            $display("%0d expected results never arrived", sb.pending.size());
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches in total", sb.errors);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
